@@ rtl/lpht_pkg.sv @@
// shared constants, types and control structs of the linear probing hash table
// no dependencies; every other rtl file takes names from here by scope
package lpht_pkg;

    localparam int TABLE_SIZE    = 16;
    localparam int PAYLOAD_WIDTH = 32;

    localparam int FUNC_W    = 2;
    localparam int KEY_W     = 16;
    localparam int IN_PAY_W  = 32;
    localparam int OUT_W     = 32;
    localparam int STORE_W   = (PAYLOAD_WIDTH < IN_PAY_W) ? PAYLOAD_WIDTH : IN_PAY_W;
    localparam int IDX_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CNT_W     = $clog2(TABLE_SIZE + 1);
    localparam bit HOME_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

    // home slot by reciprocal multiplication, exact for every 16-bit key
    localparam int RECIP_W     = 32;
    localparam int HOME_PROD_W = KEY_W + RECIP_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_W) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);

    typedef logic [FUNC_W-1:0]      func_t;
    typedef logic [KEY_W-1:0]       key_t;
    typedef logic [IN_PAY_W-1:0]    in_word_t;
    typedef logic [OUT_W-1:0]       out_word_t;
    typedef logic [STORE_W-1:0]     store_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [RECIP_W-1:0]     recip_t;
    typedef logic [HOME_PROD_W-1:0] home_prod_t;

    localparam idx_t           TABLE_LAST     = idx_t'(TABLE_SIZE - 1);
    localparam cnt_t           TABLE_SIZE_CNT = cnt_t'(TABLE_SIZE);
    localparam key_t           TABLE_SIZE_KEY = key_t'(TABLE_SIZE);
    localparam recip_t         HOME_RECIP     = recip_t'(RECIP_FULL);

    localparam func_t FUNC_INSERT = 2'd0;
    localparam func_t FUNC_LOOKUP = 2'd1;
    localparam func_t FUNC_REMOVE = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture the accepted request, start home slot unit
        logic init;       // start probing at the home slot
        logic step;       // read the slot under the pointer and advance
        logic hold;       // keep the pending read result
        logic ins_write;  // write key and payload into the free slot
        logic rem_clear;  // clear the valid mark of the matching slot
        logic finish;     // load the result register
        logic fail;       // result is table full or not found
        logic take_pay;   // result carries the stored payload
    } lpht_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        func_t op;
        logic  home_done;
        logic  free;        // slot under the pointer is empty
        logic  pend;        // a slot read is waiting to be compared
        logic  hit;         // pending read is a valid matching slot
        logic  probed_all;  // every slot has been visited
    } lpht_stat_t;

endpackage

@@ rtl/lpht_home.sv @@
// home slot unit: key modulo the table size
// mask for a power of two size, otherwise a registered reciprocal multiply; uses lpht_pkg
module lpht_home
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  lpht_pkg::key_t      key,
    output lpht_pkg::idx_t      home,
    output logic                done
);

    if (lpht_pkg::HOME_POW2) begin : g_mask
        lpht_pkg::idx_t home_reg;

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                home_reg <= key[lpht_pkg::IDX_W-1:0];
            end
        end

        assign home = home_reg;
        assign done = 1'b1;
    end else begin : g_recip
        lpht_pkg::key_t         key_reg;
        lpht_pkg::key_t         quot_reg, quot_next;
        logic                   busy_reg;
        lpht_pkg::home_prod_t   prod;
        lpht_pkg::key_t         back;
        lpht_pkg::key_t         rem;

        // quotient from the top bits of key times the rounded-up reciprocal
        assign prod      = lpht_pkg::home_prod_t'(key_reg) *
                           lpht_pkg::home_prod_t'(lpht_pkg::HOME_RECIP);
        assign quot_next = prod[lpht_pkg::HOME_PROD_W-1:lpht_pkg::RECIP_W];

        // quotient times size never exceeds the key, so 16 bits hold it
        assign back = quot_reg * lpht_pkg::TABLE_SIZE_KEY;
        assign rem  = key_reg - back;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                busy_reg <= 1'b0;
            end else begin
                busy_reg <= start;
            end
        end

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                key_reg <= key;
            end
            quot_reg <= quot_next;
        end

        assign home = rem[lpht_pkg::IDX_W-1:0];
        assign done = !busy_reg;
    end

endmodule

@@ rtl/lpht_datapath.sv @@
// datapath: request registers, probe pointer, slot memories, valid marks, result register
// depends on lpht_pkg and lpht_home
module lpht_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lpht_pkg::lpht_cmd_t    cmd,
    input  lpht_pkg::func_t        func,
    input  lpht_pkg::key_t         key,
    input  lpht_pkg::in_word_t     payload_in,
    output lpht_pkg::lpht_stat_t   stat,
    output logic                   status,
    output lpht_pkg::out_word_t    payload_out
);

    lpht_pkg::func_t   func_reg;
    lpht_pkg::key_t    key_reg;
    lpht_pkg::store_t  pay_reg;
    lpht_pkg::idx_t    ptr_reg, ptr_next;
    lpht_pkg::cnt_t    cnt_reg;
    logic              pend_reg, pend_next;
    logic              rd_valid_reg;
    lpht_pkg::key_t    rd_key_reg;
    lpht_pkg::store_t  rd_pay_reg;
    lpht_pkg::idx_t    rd_idx_reg;
    logic [lpht_pkg::TABLE_SIZE-1:0] valid_reg;
    logic              status_reg;
    lpht_pkg::out_word_t payload_out_reg;

    lpht_pkg::key_t    key_mem [lpht_pkg::TABLE_SIZE];
    lpht_pkg::store_t  pay_mem [lpht_pkg::TABLE_SIZE];

    lpht_pkg::idx_t    home;
    logic              home_done;

    lpht_home u_home
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.load),
        .key   (key),
        .home  (home),
        .done  (home_done)
    );

    assign ptr_next = (ptr_reg == lpht_pkg::TABLE_LAST) ? '0 : ptr_reg + 1'b1;

    always_comb
    begin
        if (cmd.init)
        begin
            pend_next = 1'b0;
        end else if (cmd.step)
        begin
            pend_next = 1'b1;
        end else if (cmd.hold)
        begin
            pend_next = pend_reg;
        end else begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            pend_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            pend_reg <= pend_next;
            if (cmd.init)
            begin
                cnt_reg <= '0;
            end else if (cmd.step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.ins_write)
            begin
                valid_reg[ptr_reg] <= 1'b1;
            end
            if (cmd.rem_clear)
            begin
                valid_reg[rd_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            key_reg  <= key;
            pay_reg  <= payload_in[lpht_pkg::STORE_W-1:0];
        end
        if (cmd.init)
        begin
            ptr_reg <= home;
        end else if (cmd.step)
        begin
            ptr_reg      <= ptr_next;
            rd_valid_reg <= valid_reg[ptr_reg];
            rd_idx_reg   <= ptr_reg;
        end
        if (cmd.finish)
        begin
            status_reg      <= cmd.fail;
            payload_out_reg <= cmd.take_pay ? lpht_pkg::out_word_t'(rd_pay_reg) : '0;
        end
    end

    // slot memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.ins_write)
        begin
            key_mem[ptr_reg] <= key_reg;
            pay_mem[ptr_reg] <= pay_reg;
        end
        if (cmd.step)
        begin
            rd_key_reg <= key_mem[ptr_reg];
            rd_pay_reg <= pay_mem[ptr_reg];
        end
    end

    always_comb
    begin
        stat.op         = func_reg;
        stat.home_done  = home_done;
        stat.free       = !valid_reg[ptr_reg];
        stat.pend       = pend_reg;
        stat.hit        = pend_reg && rd_valid_reg && (rd_key_reg == key_reg);
        stat.probed_all = (cnt_reg == lpht_pkg::TABLE_SIZE_CNT);
    end

    assign status      = status_reg;
    assign payload_out = payload_out_reg;

endmodule

@@ rtl/lpht_ctrl.sv @@
// controller: sequences one request through home slot, probing and result hand-off
// depends on lpht_pkg; drives the datapath commands and both handshakes
module lpht_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  lpht_pkg::lpht_stat_t   stat,
    output lpht_pkg::lpht_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HOME,
        S_PROBE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // result register can take a new result this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HOME;
                end
            end
            S_HOME:
            begin
                if (stat.home_done)
                begin
                    cmd.init   = 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                case (stat.op)
                    lpht_pkg::FUNC_INSERT:
                    begin
                        if (stat.probed_all || stat.free)
                        begin
                            if (out_free)
                            begin
                                cmd.finish    = 1'b1;
                                cmd.fail      = stat.probed_all;
                                cmd.ins_write = !stat.probed_all;
                                state_next    = S_IDLE;
                            end
                        end else begin
                            cmd.step = 1'b1;
                        end
                    end
                    lpht_pkg::FUNC_LOOKUP, lpht_pkg::FUNC_REMOVE:
                    begin
                        if (stat.hit)
                        begin
                            if (out_free)
                            begin
                                cmd.finish    = 1'b1;
                                cmd.take_pay  = (stat.op == lpht_pkg::FUNC_LOOKUP);
                                cmd.rem_clear = (stat.op == lpht_pkg::FUNC_REMOVE);
                                state_next    = S_IDLE;
                            end else begin
                                cmd.hold = 1'b1;
                            end
                        end else if (!stat.probed_all)
                        begin
                            cmd.step = 1'b1;
                        end else if (!stat.pend && out_free)
                        begin
                            cmd.finish = 1'b1;
                            cmd.fail   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        // unused code: no change, answer not found
                        if (out_free)
                        begin
                            cmd.finish = 1'b1;
                            cmd.fail   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.finish || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/linear_probe_hash_table.sv @@
// Open-addressing hash table with linear probing, keyed by a 16-bit key.
//
// Request channel (in_valid / in_stall): func selects insert, lookup or
// remove; key and payload_in go with it. A transfer happens when in_valid is
// high and in_stall is low. Result channel (out_valid / out_stall): status
// (0 success or found, 1 full or not found) and payload_out (stored word on
// a lookup hit, zero otherwise). Every request gives exactly one result.
//
// One request is worked at a time. A request is loaded, then its home slot
// is found (a mask, or when the table size is not a power of two a reciprocal
// multiply, then multiply back and subtract), then one slot read per cycle
// goes through the slot memory port, up to TABLE_SIZE reads, and the last
// read is compared before the hand-off.
// The result register frees the request side: the next request is taken
// while a result still waits. A stalled receiver holds the result steady;
// a finished request then waits for the result register before completing.
// Reset clears every valid mark, so the table starts empty and is ready at
// once; slot keys and payloads are not cleared.
// Depends on lpht_pkg, lpht_ctrl and lpht_datapath.
module linear_probe_hash_table
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  lpht_pkg::func_t      func,
    input  lpht_pkg::key_t       key,
    input  lpht_pkg::in_word_t   payload_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 status,
    output lpht_pkg::out_word_t  payload_out
);

    lpht_pkg::lpht_cmd_t  cmd;
    lpht_pkg::lpht_stat_t stat;

    lpht_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    lpht_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .func        (func),
        .key         (key),
        .payload_in  (payload_in),
        .stat        (stat),
        .status      (status),
        .payload_out (payload_out)
    );

endmodule

@@ rtl/lpht_check.sv @@
// port-level checks of the hash table, attached to the top level by bind
// depends on lpht_pkg and linear_probe_hash_table
module lpht_check
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic                 status,
    input lpht_pkg::out_word_t  payload_out
);

    // a stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(payload_out))
        else $error("result changed while stalled");

    // failures never carry data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> payload_out == '0)
        else $error("failed result with nonzero payload");

    // one request at a time: busy right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while busy");

    // a new result only comes out of a request in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result with no request in progress");

endmodule

bind linear_probe_hash_table lpht_check u_lpht_check
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .payload_out (payload_out)
);
